// ----- rtl/emfp_pkg.sv -----
// ----------------------------------------------------------------------------
// emfp_pkg
// Shared constants and types for the energy meter frame parser.
// ----------------------------------------------------------------------------
package emfp_pkg;

   localparam int unsigned FrameLen = 24;   // bytes in one frame window
   localparam int unsigned FillW    = 5;
   localparam int unsigned MemAddrW = 6;
   localparam int unsigned MemDepth = 1 << MemAddrW;
   localparam int unsigned IdxW     = 5;

   localparam logic [7:0] SyncByte   = 8'h5A;
   localparam logic [7:0] GoodStatus = 8'h55;

   typedef logic [MemAddrW-1:0] addr_type;
   typedef logic [FillW-1:0]    fill_type;
   typedef logic [IdxW-1:0]     idx_type;

   // fill level at which the byte leaving window position 2 is a real byte
   localparam fill_type FillLag   = fill_type'(FrameLen - 2);
   // fill level before a byte that completes a full window
   localparam fill_type FillMatch = fill_type'(FrameLen - 1);
   localparam fill_type FillFull  = fill_type'(FrameLen);

   localparam addr_type LagOffset  = addr_type'(FrameLen - 2);
   localparam addr_type BaseOffset = addr_type'(FrameLen - 1);

   // frame bytes 0..22 are read back; byte 23 is the checksum
   localparam idx_type  IdxLast = idx_type'(FrameLen - 2);

   typedef struct packed {
      logic     valid;
      addr_type base;   // memory address of frame byte 0
   } match_type;

endpackage

// ----- rtl/emfp_scan.sv -----
// ----------------------------------------------------------------------------
// emfp_scan
// Byte window memory, running checksum and sync/checksum frame detection.
// ----------------------------------------------------------------------------
module emfp_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 frame_busy,
   output emfp_pkg::match_type  match,
   input  emfp_pkg::addr_type   rd_b_addr,
   output logic [7:0]           rd_b_data
);

   logic [7:0] win_mem [emfp_pkg::MemDepth];

   emfp_pkg::addr_type wr_ptr_ff, wr_ptr_in;
   logic               s1_valid_ff;
   logic [7:0]         s1_byte_ff;
   emfp_pkg::addr_type s1_addr_ff;
   logic [7:0]         rd_a_ff;
   logic [7:0]         rd_b_ff;
   emfp_pkg::fill_type fill_ff, fill_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         prev_ff, prev_in;

   emfp_pkg::fill_type pending;
   logic               req_xfer;
   logic [7:0]         drop;
   logic [7:0]         sum_step;
   logic               hit;

   // hold off the byte that could complete a window while a frame is read out or held
   assign pending   = fill_ff + emfp_pkg::fill_type'(s1_valid_ff);
   assign req_ready = !(frame_busy && (pending >= emfp_pkg::FillMatch));
   assign req_xfer  = req_valid && req_ready;

   // window memory: write port, checksum read port, frame readout port
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         win_mem[wr_ptr_ff] <= req_rx_byte;
      end
      rd_a_ff <= win_mem[wr_ptr_ff - emfp_pkg::LagOffset];
      rd_b_ff <= win_mem[rd_b_addr];
   end

   assign rd_b_data = rd_b_ff;

   // byte leaving position 2 (also the new position 1); zero until written
   assign drop     = (fill_ff >= emfp_pkg::FillLag) ? rd_a_ff : 8'h00;
   assign sum_step = sum_ff - drop + prev_ff;
   assign hit      = s1_valid_ff && (fill_ff >= emfp_pkg::FillMatch) &&
                     (drop == emfp_pkg::SyncByte) && (s1_byte_ff == sum_step);

   always_comb begin
      wr_ptr_in = req_xfer ? wr_ptr_ff + emfp_pkg::addr_type'(1) : wr_ptr_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      prev_in   = prev_ff;
      if (s1_valid_ff) begin
         if (hit) begin
            fill_in = '0;
            sum_in  = '0;
            prev_in = '0;
         end else begin
            fill_in = (fill_ff == emfp_pkg::FillFull) ? fill_ff :
                      fill_ff + emfp_pkg::fill_type'(1);
            sum_in  = sum_step;
            prev_in = s1_byte_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         s1_valid_ff <= 1'b0;
         fill_ff     <= '0;
         sum_ff      <= '0;
         prev_ff     <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         s1_valid_ff <= req_xfer;
         fill_ff     <= fill_in;
         sum_ff      <= sum_in;
         prev_ff     <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff <= req_rx_byte;
         s1_addr_ff <= wr_ptr_ff;
      end
   end

   assign match.valid = hit;
   assign match.base  = s1_addr_ff - emfp_pkg::BaseOffset;

   a_match_when_idle: assert property (@(posedge clock) disable iff (reset)
      match.valid |-> !frame_busy)
      else $error("frame match while readout busy");

   a_fill_saturates: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= emfp_pkg::FillFull)
      else $error("fill count past window length");

endmodule

// ----- rtl/emfp_frame.sv -----
// ----------------------------------------------------------------------------
// emfp_frame
// Frame readout from the window memory, pulse total update, result register.
// ----------------------------------------------------------------------------
module emfp_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  emfp_pkg::match_type  match,
   output logic                 frame_busy,
   output emfp_pkg::addr_type   rd_b_addr,
   input  logic [7:0]           rd_b_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_status_ok,
   output logic [7:0]           rsp_status_byte,
   output logic [23:0]          rsp_voltage_param_raw,
   output logic [23:0]          rsp_voltage_period,
   output logic [23:0]          rsp_current_param_raw,
   output logic [23:0]          rsp_current_period,
   output logic [23:0]          rsp_power_param_raw,
   output logic [23:0]          rsp_power_period,
   output logic [7:0]           rsp_update_flags,
   output logic [15:0]          rsp_pulse_count_raw,
   output logic signed [63:0]   rsp_energy_pulse_total
);

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_LAST, ST_HOLD} state_type;

   state_type          state_ff;
   emfp_pkg::addr_type base_ff;
   emfp_pkg::idx_type  idx_ff;
   logic               cap_valid_ff;
   emfp_pkg::idx_type  cap_idx_ff;
   logic [7:0]         frm_ff [emfp_pkg::FrameLen-1];

   logic [63:0]        total_ff;
   logic [15:0]        last_count_ff;
   logic               last_ovf_ff;
   logic               primed_ff;

   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic [7:0]         rsp_status_ff;
   logic [23:0]        rsp_vparam_ff, rsp_volt_ff;
   logic [23:0]        rsp_cparam_ff, rsp_curr_ff;
   logic [23:0]        rsp_pparam_ff, rsp_power_ff;
   logic [7:0]         rsp_flags_ff;
   logic [15:0]        rsp_count_ff;
   logic [63:0]        rsp_total_ff;

   logic [15:0]        count;
   logic               ovf;
   logic               good;
   logic [16:0]        diff;
   logic [17:0]        delta;
   logic [63:0]        total_sum;
   logic [63:0]        total_in;
   logic               load;

   assign count     = {frm_ff[21], frm_ff[22]};
   assign ovf       = frm_ff[20][7];
   assign good      = (frm_ff[0] == emfp_pkg::GoodStatus);
   // count delta as a signed 17-bit value, plus the wrap when bit 7 toggled
   assign diff      = {1'b0, count} - {1'b0, last_count_ff};
   assign delta     = {diff[16], diff} + {1'b0, ovf != last_ovf_ff, 16'h0000};
   assign total_sum = total_ff + {{46{delta[17]}}, delta};
   assign total_in  = (good && primed_ff) ? total_sum : total_ff;
   assign load      = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_ready);

   assign rd_b_addr  = base_ff + emfp_pkg::addr_type'(idx_ff);
   assign frame_busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         total_ff      <= '0;
         last_count_ff <= '0;
         last_ovf_ff   <= 1'b0;
         primed_ff     <= 1'b0;
      end else begin
         cap_valid_ff <= (state_ff == ST_READ);
         cap_idx_ff   <= idx_ff;
         if (cap_valid_ff) begin
            frm_ff[cap_idx_ff] <= rd_b_data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (match.valid) begin
                  base_ff  <= match.base;
                  idx_ff   <= '0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (idx_ff == emfp_pkg::IdxLast) begin
                  state_ff <= ST_LAST;
               end else begin
                  idx_ff <= idx_ff + emfp_pkg::idx_type'(1);
               end
            end
            ST_LAST: begin
               state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               if (load) begin
                  rsp_ok_ff     <= good;
                  rsp_status_ff <= frm_ff[0];
                  rsp_vparam_ff <= {frm_ff[2], frm_ff[3], frm_ff[4]};
                  rsp_volt_ff   <= {frm_ff[5], frm_ff[6], frm_ff[7]};
                  rsp_cparam_ff <= {frm_ff[8], frm_ff[9], frm_ff[10]};
                  rsp_curr_ff   <= {frm_ff[11], frm_ff[12], frm_ff[13]};
                  rsp_pparam_ff <= {frm_ff[14], frm_ff[15], frm_ff[16]};
                  rsp_power_ff  <= {frm_ff[17], frm_ff[18], frm_ff[19]};
                  rsp_flags_ff  <= frm_ff[20];
                  rsp_count_ff  <= count;
                  rsp_total_ff  <= total_in;
                  total_ff      <= total_in;
                  if (good) begin
                     primed_ff     <= 1'b1;
                     last_count_ff <= count;
                     last_ovf_ff   <= ovf;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status_ok          = rsp_ok_ff;
   assign rsp_status_byte        = rsp_status_ff;
   assign rsp_voltage_param_raw  = rsp_vparam_ff;
   assign rsp_voltage_period     = rsp_volt_ff;
   assign rsp_current_param_raw  = rsp_cparam_ff;
   assign rsp_current_period     = rsp_curr_ff;
   assign rsp_power_param_raw    = rsp_pparam_ff;
   assign rsp_power_period       = rsp_power_ff;
   assign rsp_update_flags       = rsp_flags_ff;
   assign rsp_pulse_count_raw    = rsp_count_ff;
   assign rsp_energy_pulse_total = signed'(rsp_total_ff);

   a_hold_until_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_HOLD)
      else $error("frame dropped while result register full");

   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_HOLD)
      else $error("result raised without a completed frame");

endmodule

// ----- rtl/energy_meter_frame_parser.sv -----
// ----------------------------------------------------------------------------
// energy_meter_frame_parser
// Serial frame scanner and pulse accumulator for a metering chip byte stream.
// ----------------------------------------------------------------------------
// Takes one received byte per clock and scans a 24-byte sliding window for a
// frame: byte 1 = 0x5A and byte 23 = low 8 bits of the sum of bytes 2..22.
// Bytes go into a 64-entry window memory; one read port fetches the byte that
// leaves the checksum span so the running sum and sync test are updated as
// each byte arrives. On a match the window restarts empty and the frame is
// read back through the second read port, one byte per cycle, then decoded
// into the result register; rsp_valid rises when the decoded frame is loaded,
// which waits while the previous result has not been taken. Input rate is one
// transfer per clock while req_ready is high; while a frame is still being
// read out or waits to enter the result register, req_ready drops once the
// next window is 23 bytes full, so a continuous stream stalls then, longer if
// the result side holds off. Frames with status 0x55 are good and update the
// signed 64-bit pulse total; the first good frame after reset only records
// the count and overflow bit. Bad-status frames are still reported with
// status_ok low and the unchanged total.
// ----------------------------------------------------------------------------
module energy_meter_frame_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_status_ok,
   output logic [7:0]          rsp_status_byte,
   output logic [23:0]         rsp_voltage_param_raw,
   output logic [23:0]         rsp_voltage_period,
   output logic [23:0]         rsp_current_param_raw,
   output logic [23:0]         rsp_current_period,
   output logic [23:0]         rsp_power_param_raw,
   output logic [23:0]         rsp_power_period,
   output logic [7:0]          rsp_update_flags,
   output logic [15:0]         rsp_pulse_count_raw,
   output logic signed [63:0]  rsp_energy_pulse_total
);

   emfp_pkg::match_type match;      // frame found, with its base address
   logic                frame_busy; // readout or result pending
   emfp_pkg::addr_type  rd_b_addr;
   logic [7:0]          rd_b_data;

   // window memory, running checksum and frame detection
   emfp_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .frame_busy  (frame_busy),
      .match       (match),
      .rd_b_addr   (rd_b_addr),
      .rd_b_data   (rd_b_data)
   );

   // frame readout, field decode, pulse total and result register
   emfp_frame u_frame (
      .clock                  (clock),
      .reset                  (reset),
      .match                  (match),
      .frame_busy             (frame_busy),
      .rd_b_addr              (rd_b_addr),
      .rd_b_data              (rd_b_data),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status_ok          (rsp_status_ok),
      .rsp_status_byte        (rsp_status_byte),
      .rsp_voltage_param_raw  (rsp_voltage_param_raw),
      .rsp_voltage_period     (rsp_voltage_period),
      .rsp_current_param_raw  (rsp_current_param_raw),
      .rsp_current_period     (rsp_current_period),
      .rsp_power_param_raw    (rsp_power_param_raw),
      .rsp_power_period       (rsp_power_period),
      .rsp_update_flags       (rsp_update_flags),
      .rsp_pulse_count_raw    (rsp_pulse_count_raw),
      .rsp_energy_pulse_total (rsp_energy_pulse_total)
   );

endmodule
